// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: hdl/zcd_pkg.sv
package zcd_pkg;

	// Image bounds; pixels outside them do not take part in counting.
	localparam int unsigned IMAGE_COLUMNS = 128;
	localparam int unsigned IMAGE_ROWS    = 64;

	// Field widths.
	localparam int ROW_W   = 6;
	localparam int COL_W   = 7;
	localparam int FRAME_W = 16;
	localparam int TRANS_W = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Register reset values.
	localparam logic [FRAME_W-1:0] WARMUP_RESET     = 16'd600;
	localparam logic [TRANS_W-1:0] TRANS_LIMIT_RESET = 8'd10;
	localparam logic [ROW_W-1:0]   ROW_LIMIT_RESET   = 6'd4;
	localparam logic [ROW_W-1:0]   SCAN_TOP_RESET    = 6'd38;
	localparam logic [ROW_W-1:0]   SCAN_BOTTOM_RESET = 6'd15;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WARMUP_FRAMES    = 3'd0,
		REG_TRANSITION_LIMIT = 3'd1,
		REG_ROW_LIMIT        = 3'd2,
		REG_SCAN_TOP_ROW     = 3'd3,
		REG_SCAN_BOTTOM_ROW  = 3'd4
	} cfg_reg_t;

	// Current configuration as seen by the detector core.
	typedef struct packed {
		logic [FRAME_W-1:0] warmup_frames;
		logic [TRANS_W-1:0] transition_limit;
		logic [ROW_W-1:0]   row_limit;
		logic [ROW_W-1:0]   scan_top_row;
		logic [ROW_W-1:0]   scan_bottom_row;
	} cfg_t;

	// One input word.
	typedef struct packed {
		logic             frame_start;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] column_index;
		logic             pixel_value;
		logic [COL_W-1:0] left_edge;
		logic [COL_W-1:0] right_edge;
	} pixel_t;

	// One result word.
	typedef struct packed {
		logic             stop_flag;
		logic [ROW_W-1:0] crossing_row;
		logic [ROW_W-1:0] striped_rows;
	} result_t;

endpackage

// File: hdl/zcd_core.sv
module zcd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  zcd_pkg::cfg_t   cfg,
	input  logic            pix_accept,
	input  zcd_pkg::pixel_t pix,
	output zcd_pkg::result_t result
);
	import zcd_pkg::*;

	`include "assert_macros.svh"

	logic [FRAME_W-1:0] frame_count_q;
	logic               previous_pixel_q;
	logic [TRANS_W-1:0] row_changes_q;
	logic               row_counted_q;
	logic [ROW_W-1:0]   striped_count_q;
	logic               frame_finished_q;
	logic               detected_q;
	logic [ROW_W-1:0]   found_row_q;

	logic [FRAME_W-1:0] frame_count_d;
	logic [TRANS_W-1:0] row_changes_0;
	logic [TRANS_W-1:0] row_changes_d;
	logic               row_counted_0;
	logic               row_counted_d;
	logic [ROW_W-1:0]   striped_0;
	logic [ROW_W-1:0]   striped_d;
	logic               finished_0;
	logic               finished_d;
	logic               detected_d;
	logic [ROW_W-1:0]   found_row_d;
	logic               active;
	logic               in_bounds;
	logic               pair_counts;
	logic               change_hit;

	// Next state for one pixel: frame start, row start, counting, then detection.
	always_comb begin
		frame_count_d = frame_count_q;
		striped_0     = striped_count_q;
		finished_0    = frame_finished_q;
		if (pix.frame_start) begin
			if (frame_count_q < cfg.warmup_frames) begin
				frame_count_d = frame_count_q + FRAME_W'(1);
			end
			striped_0  = '0;
			finished_0 = 1'b0;
		end

		row_changes_0 = row_changes_q;
		row_counted_0 = row_counted_q;
		if (pix.column_index == '0) begin
			row_changes_0 = '0;
			row_counted_0 = 1'b0;
		end

		in_bounds = (32'(pix.row_index) < IMAGE_ROWS) &&
			(32'(pix.column_index) < IMAGE_COLUMNS);
		active = (frame_count_d >= cfg.warmup_frames) && !finished_0 &&
			(pix.row_index > cfg.scan_bottom_row) &&
			(pix.row_index <= cfg.scan_top_row) && in_bounds;

		pair_counts = (pix.left_edge != '0) && (pix.right_edge != '0) &&
			(pix.column_index > pix.left_edge) &&
			(pix.column_index <= pix.right_edge) &&
			!row_counted_0 && (pix.pixel_value != previous_pixel_q);
		change_hit = active && pair_counts;

		row_changes_d = row_changes_0;
		row_counted_d = row_counted_0;
		striped_d     = striped_0;
		if (change_hit) begin
			if (row_changes_0 != '1) begin
				row_changes_d = row_changes_0 + TRANS_W'(1);
			end
			if (row_changes_d > cfg.transition_limit) begin
				row_counted_d = 1'b1;
				if (striped_0 != '1) begin
					striped_d = striped_0 + ROW_W'(1);
				end
			end
		end

		detected_d  = detected_q;
		found_row_d = found_row_q;
		finished_d  = finished_0;
		if (active && (striped_d > cfg.row_limit)) begin
			detected_d  = 1'b1;
			found_row_d = pix.row_index;
			finished_d  = 1'b1;
		end
	end

	// Detector state, updated once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q    <= '0;
			previous_pixel_q <= 1'b0;
			row_changes_q    <= '0;
			row_counted_q    <= 1'b0;
			striped_count_q  <= '0;
			frame_finished_q <= 1'b0;
			detected_q       <= 1'b0;
			found_row_q      <= '0;
		end else if (pix_accept) begin
			frame_count_q    <= frame_count_d;
			previous_pixel_q <= pix.pixel_value;
			row_changes_q    <= row_changes_d;
			row_counted_q    <= row_counted_d;
			striped_count_q  <= striped_d;
			frame_finished_q <= finished_d;
			detected_q       <= detected_d;
			found_row_q      <= found_row_d;
		end
	end

	// The result reflects the state after this pixel.
	assign result.stop_flag    = detected_d;
	assign result.crossing_row = found_row_d;
	assign result.striped_rows = striped_d;

	// Stop flag is sticky, and a finished frame always comes from a detection.
	`ASSERT_PROP(a_stop_sticky, clk, arst_n, detected_q |=> detected_q)
	`ASSERT_NEVER(a_finish_needs_detect, clk, arst_n, frame_finished_q && !detected_q)
	`ASSERT_PROP(a_state_holds_idle, clk, arst_n,
		!pix_accept |=> $stable(striped_count_q) && $stable(frame_count_q))

endmodule

// File: hdl/zcd_out_buf.sv
module zcd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  zcd_pkg::result_t  push_word,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output zcd_pkg::result_t  out_word
);
	import zcd_pkg::*;

	`include "assert_macros.svh"

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	// Two entries let the input side keep going while a result waits.
	assign can_push  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_word  = entry_q[rd_ptr_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && count_q == 2'd2)
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q == 2'd3)
	`ASSERT_PROP(a_ptr_match, clk, arst_n,
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))

endmodule

// File: hdl/zebra_crossing_detector.sv
// Zebra crossing detector on a binary pixel stream. Each input word is one pixel
// with its row, column and the track edges of its row; each accepted word gives
// exactly one result word (stop flag, row of the latest detection, and striped
// rows counted so far in the frame). One pixel is taken every clock cycle while
// in_ready is high. Each result word is held in a two-word output buffer, which
// lets pixels keep flowing during a downstream stall until both entries are full,
// when in_ready drops. Rows must arrive in descending order and pixels in
// ascending column order. Configuration writes take effect at once and should be
// done while the stream is idle.
module zebra_crossing_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_write_en,
	input  logic [zcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [zcd_pkg::CFG_W-1:0]   cfg_data,
	// Pixel channel.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        frame_start,
	input  logic [zcd_pkg::ROW_W-1:0]   row_index,
	input  logic [zcd_pkg::COL_W-1:0]   column_index,
	input  logic                        pixel_value,
	input  logic [zcd_pkg::COL_W-1:0]   left_edge,
	input  logic [zcd_pkg::COL_W-1:0]   right_edge,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        stop_flag,
	output logic [zcd_pkg::ROW_W-1:0]   crossing_row,
	output logic [zcd_pkg::ROW_W-1:0]   striped_rows
);
	import zcd_pkg::*;

	cfg_t    cfg_q;
	pixel_t  pix;
	result_t core_result;
	result_t out_word;
	logic    pix_accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_frames    <= WARMUP_RESET;
			cfg_q.transition_limit <= TRANS_LIMIT_RESET;
			cfg_q.row_limit        <= ROW_LIMIT_RESET;
			cfg_q.scan_top_row     <= SCAN_TOP_RESET;
			cfg_q.scan_bottom_row  <= SCAN_BOTTOM_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_WARMUP_FRAMES:    cfg_q.warmup_frames    <= cfg_data;
				REG_TRANSITION_LIMIT: cfg_q.transition_limit <= cfg_data[TRANS_W-1:0];
				REG_ROW_LIMIT:        cfg_q.row_limit        <= cfg_data[ROW_W-1:0];
				REG_SCAN_TOP_ROW:     cfg_q.scan_top_row     <= cfg_data[ROW_W-1:0];
				REG_SCAN_BOTTOM_ROW:  cfg_q.scan_bottom_row  <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Gather the pixel word.
	assign pix.frame_start  = frame_start;
	assign pix.row_index    = row_index;
	assign pix.column_index = column_index;
	assign pix.pixel_value  = pixel_value;
	assign pix.left_edge    = left_edge;
	assign pix.right_edge   = right_edge;

	assign pix_accept = in_valid && in_ready;

	zcd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix_accept (pix_accept),
		.pix        (pix),
		.result     (core_result)
	);

	zcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pix_accept),
		.push_word (core_result),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign stop_flag    = out_word.stop_flag;
	assign crossing_row = out_word.crossing_row;
	assign striped_rows = out_word.striped_rows;

endmodule
